// ===== design/assert_macros.svh =====
// assertion macros used by the hash table top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expr must hold at every clock edge outside reset
`define LPHT_ASSERT(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("lpht assertion failed");
// cons must hold in every cycle in which ante holds
`define LPHT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpht implication failed");
`else
`define LPHT_ASSERT(label, clk, rst, expr)
`define LPHT_ASSERT_IMP(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/lpht_pkg.sv =====
// shared types and codes of the linear probe hash table
package lpht_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

endpackage

// ===== design/linear_probe_hash_table_unit.sv =====
// top level of the linear probe hash table
// An open-addressing hash table of TABLE_SIZE slots, all empty after reset. A request is
// taken when start is high and busy is low; opcode selects insert or delete of value.
// Each request gives one result on status, slot and occupancy for the single cycle in
// which done is high; the receiver cannot stall it, and a new request may be taken in
// that same cycle. An insert into a full table or a delete from an empty one answers in
// the cycle after the request. Otherwise the home slot (value modulo TABLE_SIZE) comes
// from a reciprocal multiply unit, then the probe visits one slot a cycle. Insert probes
// the flip-flop valid marks; delete reads the value ram, one read per cycle, and compares
// the registered data in the following cycle. Duplicate values are stored in separate slots.
`include "assert_macros.svh"

module linear_probe_hash_table_unit #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                opcode,
  input  logic [31:0]                         value,
  output logic                                done,
  output lpht_pkg::status_t                   status,
  output logic [$clog2(TABLE_SIZE)-1:0]       slot,
  output logic [$clog2(TABLE_SIZE+1)-1:0]     occupancy
);

  localparam int SLOT_W = $clog2(TABLE_SIZE);
  localparam int CNT_W  = $clog2(TABLE_SIZE + 1);

  typedef enum logic [1:0] {S_IDLE, S_HASH, S_INS, S_DEL} state_t;

  state_t            state;
  logic              op_q;
  logic [31:0]       value_q;
  logic [TABLE_SIZE-1:0] valid;
  logic [CNT_W-1:0]  count;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] cur;
  logic [CNT_W-1:0]  probes;

  logic              accept;
  logic              early;
  logic              hash_go;
  logic              home_done;
  logic [SLOT_W-1:0] home;
  logic [SLOT_W:0]   idx_sum;
  logic [SLOT_W:0]   home_sum;
  logic [SLOT_W-1:0] idx_inc;
  logic [SLOT_W-1:0] home_inc;
  logic              ram_we;
  logic [SLOT_W-1:0] raddr;
  logic [31:0]       rdata;
  logic              match;

  assign busy    = (state != S_IDLE);
  assign accept  = start && (state == S_IDLE);
  assign early   = ((opcode == lpht_pkg::OP_INSERT) && (count == CNT_W'(TABLE_SIZE))) ||
                   ((opcode == lpht_pkg::OP_DELETE) && (count == '0));
  assign hash_go = accept && !early;

  lpht_mod #(
    .DIVISOR (TABLE_SIZE),
    .WIDTH   (32)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (hash_go),
    .dividend (value),
    .done     (home_done),
    .rem_out  (home)
  );

  // next slot with wrap
  assign idx_sum  = {1'b0, idx} + (SLOT_W+1)'(1);
  assign home_sum = {1'b0, home} + (SLOT_W+1)'(1);
  assign idx_inc  = (idx_sum == (SLOT_W+1)'(TABLE_SIZE)) ? '0 : idx_sum[SLOT_W-1:0];
  assign home_inc = (home_sum == (SLOT_W+1)'(TABLE_SIZE)) ? '0 : home_sum[SLOT_W-1:0];

  assign ram_we = (state == S_INS) && !valid[idx];
  assign raddr  = (state == S_HASH) ? home : idx;
  // rdata belongs to cur, read in the previous cycle
  assign match  = valid[cur] && (rdata == value_q);

  lpht_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (value_q),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      count <= '0;
      valid <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_q    <= opcode;
            value_q <= value;
            if (early) begin
              done      <= 1'b1;
              status    <= (opcode == lpht_pkg::OP_INSERT) ? lpht_pkg::ST_FULL
                                                           : lpht_pkg::ST_EMPTY;
              slot      <= '0;
              occupancy <= count;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (home_done) begin
            if (op_q == lpht_pkg::OP_INSERT) begin
              idx   <= home;
              state <= S_INS;
            end else begin
              cur    <= home;
              idx    <= home_inc;
              probes <= '0;
              state  <= S_DEL;
            end
          end
        end
        S_INS: begin
          // a free slot exists since the table was not full
          if (!valid[idx]) begin
            valid[idx] <= 1'b1;
            count      <= count + CNT_W'(1);
            done       <= 1'b1;
            status     <= lpht_pkg::ST_INSERTED;
            slot       <= idx;
            occupancy  <= count + CNT_W'(1);
            state      <= S_IDLE;
          end else begin
            idx <= idx_inc;
          end
        end
        S_DEL: begin
          if (match) begin
            valid[cur] <= 1'b0;
            count      <= count - CNT_W'(1);
            done       <= 1'b1;
            status     <= lpht_pkg::ST_DELETED;
            slot       <= cur;
            occupancy  <= count - CNT_W'(1);
            state      <= S_IDLE;
          end else if (probes == CNT_W'(TABLE_SIZE - 1)) begin
            done      <= 1'b1;
            status    <= lpht_pkg::ST_NOT_FOUND;
            slot      <= '0;
            occupancy <= count;
            state     <= S_IDLE;
          end else begin
            cur    <= idx;
            idx    <= idx_inc;
            probes <= probes + CNT_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `LPHT_ASSERT(a_count_matches_valid, clk, rst, $countones(valid) == count)
  `LPHT_ASSERT_IMP(a_done_not_busy, clk, rst, done, !busy)
  `LPHT_ASSERT_IMP(a_insert_marks, clk, rst, done && (status == lpht_pkg::ST_INSERTED), valid[slot])
  `LPHT_ASSERT_IMP(a_delete_clears, clk, rst, done && (status == lpht_pkg::ST_DELETED), !valid[slot])

endmodule

// ===== design/lpht_ram.sv =====
// generic single-write single-read ram with registered read data
module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lpht_mod.sv =====
// remainder unit: value modulo DIVISOR by reciprocal multiplication
module lpht_mod #(
  parameter int DIVISOR = 16,
  parameter int WIDTH   = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [WIDTH-1:0]           dividend,
  output logic                       done,
  output logic [$clog2(DIVISOR)-1:0] rem_out
);

  localparam int REM_W = $clog2(DIVISOR);
  // ceil(2^(WIDTH+REM_W) / DIVISOR) gives the exact quotient for every dividend
  localparam longint unsigned MAGIC_L =
    ((64'd1 << (WIDTH + REM_W)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [WIDTH:0]   MAGIC  = (WIDTH+1)'(MAGIC_L);
  localparam logic [REM_W-1:0] DIV_LO = REM_W'(DIVISOR);

  logic [WIDTH-1:0] operand;
  logic [REM_W-1:0] quot_lo;
  logic             product_valid;
  logic [2*WIDTH:0] product;

  assign product = {{(WIDTH+1){1'b0}}, operand} * {{WIDTH{1'b0}}, MAGIC};
  // the remainder fits in REM_W bits, so only the low quotient bits matter
  assign rem_out = operand[REM_W-1:0] - quot_lo * DIV_LO;

  always_ff @(posedge clk) begin
    if (rst) begin
      product_valid <= 1'b0;
      done          <= 1'b0;
    end else begin
      product_valid <= start;
      done          <= product_valid;
    end
    if (start) begin
      operand <= dividend;
    end
    if (product_valid) begin
      quot_lo <= product[WIDTH+REM_W +: REM_W];
    end
  end

endmodule
